### rtl/tas_pkg.sv
// ----------------------------------------------------------------------------
// tas_pkg
// shared constants, types and the arctangent table of the tilt smoother
// ----------------------------------------------------------------------------
package tas_pkg;

    // cordic iterations and fraction bits of the fixed-point angle
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 8;

    localparam int STEP_W    = $clog2(CORDIC_STEPS);
    localparam int TAB_IDX_W = 5;
    localparam int TAB_FRAC  = 16;
    localparam int ATAN_W    = 23;

    // cordic vector and angle accumulator widths
    localparam int XY_W = 26;
    localparam int Z_W  = 24;

    // signed angle in degrees, magnitude up to 90
    localparam int A_W    = 8 + ANGLE_FRAC_BITS;
    localparam int AMAG_W = A_W - 1;
    localparam logic [AMAG_W-1:0] ANGLE_LIM = AMAG_W'(90 << ANGLE_FRAC_BITS);

    // multiply-accumulate operand and accumulator widths
    localparam int MA_W  = (A_W > 16) ? A_W : 16;
    localparam int MB_W  = 16;
    localparam int ACC_W = (MA_W + MB_W > 34) ? MA_W + MB_W : 34;

    // smoothing divides by 256 * 2^ANGLE_FRAC_BITS
    localparam int SMOOTH_SH = 8 + ANGLE_FRAC_BITS;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int W_W    = 9;
    localparam logic [W_W-1:0]    WEIGHT_ONE   = 9'd256;
    localparam logic [W_W-1:0]    WEIGHT_RESET = 9'd128;
    localparam logic [DATA_W-1:0] THRESH_RESET = 32'h9000_0000;

    typedef enum logic
    {
        REG_WEIGHT = 1'b0,
        REG_THRESH = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [W_W-1:0]    weight;
        logic [DATA_W-1:0] threshold;
    } cfg_t;

    typedef struct packed
    {
        logic load;
        logic iterate;
    } cordic_ctrl_t;

    typedef struct packed
    {
        logic en;
        logic clr;
    } mac_ctrl_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [TAB_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919880;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/tas_if.sv
// ----------------------------------------------------------------------------
// tas_in_if / tas_out_if
// valid/ready channels carrying samples in and smoothed angles out
// ----------------------------------------------------------------------------
interface tas_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;

    modport source (output valid, command, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, command, accel_x, accel_y, accel_z, output ready);
endinterface

interface tas_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] smoothed_angle;
    logic signed [7:0] tilt_angle;
    logic              impact;

    modport source (output valid, smoothed_angle, tilt_angle, impact, input ready);
    modport sink   (input valid, smoothed_angle, tilt_angle, impact, output ready);
endinterface

### rtl/tas_regs.sv
// ----------------------------------------------------------------------------
// tas_regs
// apb-style register file: smoothing weight and impact threshold
// ----------------------------------------------------------------------------
module tas_regs import tas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [W_W-1:0]    weight_reg;
    logic [DATA_W-1:0] thresh_reg;
    reg_idx_t          idx;
    logic              wr_en;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_WEIGHT: weight_reg <= pwdata[W_W-1:0];
                REG_THRESH: thresh_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_WEIGHT: prdata = DATA_W'(weight_reg);
            REG_THRESH: prdata = thresh_reg;
        endcase
    end

    assign cfg.weight    = weight_reg;
    assign cfg.threshold = thresh_reg;

endmodule

### rtl/tas_cordic.sv
// ----------------------------------------------------------------------------
// tas_cordic
// vectoring cordic, one shift-add rotation per clock while iterate is set
// ----------------------------------------------------------------------------
module tas_cordic import tas_pkg::*;
(
    input  logic                   clk,
    input  cordic_ctrl_t           ctrl,
    input  logic signed [15:0]     x,
    input  logic signed [15:0]     y,
    input  logic [STEP_W-1:0]      step,
    output logic signed [Z_W-1:0]  z
);

    logic signed [XY_W-1:0] cx_reg, cx_next;
    logic signed [XY_W-1:0] cy_reg, cy_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic signed [XY_W-1:0] xe, ye, dx, dy;
    logic signed [Z_W-1:0]  at;

    assign xe = XY_W'(x);
    assign ye = XY_W'(y);
    assign dx = cy_reg >>> step;
    assign dy = cx_reg >>> step;
    assign at = $signed(Z_W'(atan_q16(TAB_IDX_W'(step))));

    always_comb
    begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        z_next  = z_reg;
        if (ctrl.load)
        begin
            // left half-plane: mirror through the origin
            cx_next = (x < 0) ? (-xe) <<< 8 : xe <<< 8;
            cy_next = (x < 0) ? (-ye) <<< 8 : ye <<< 8;
            z_next  = '0;
        end
        else if (ctrl.iterate)
        begin
            if (cy_reg > 0)
            begin
                cx_next = cx_reg + dx;
                cy_next = cy_reg - dy;
                z_next  = z_reg + at;
            end
            else if (cy_reg < 0)
            begin
                cx_next = cx_reg - dx;
                cy_next = cy_reg + dy;
                z_next  = z_reg - at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        z_reg  <= z_next;
    end

    assign z = z_reg;

endmodule

### rtl/tas_mac.sv
// ----------------------------------------------------------------------------
// tas_mac
// shared signed multiply-accumulate unit
// ----------------------------------------------------------------------------
module tas_mac import tas_pkg::*;
(
    input  logic                    clk,
    input  mac_ctrl_t               ctrl,
    input  logic signed [MA_W-1:0]  op_a,
    input  logic signed [MB_W-1:0]  op_b,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [MA_W+MB_W-1:0] prod;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;

    assign prod     = op_a * op_b;
    assign acc_next = (ctrl.clr ? '0 : acc_reg) + ACC_W'(prod);

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

### rtl/tilt_angle_smoother_with_impact.sv
// ----------------------------------------------------------------------------
// tilt_angle_smoother_with_impact
// accelerometer tilt angle with exponential smoothing and sticky impact flag
// ----------------------------------------------------------------------------
// Each sample transaction (command 0) carries a signed x, y, z reading. The
// block returns one result transaction per input: the tilt atan(y/x) in whole
// degrees truncated toward zero, the smoothed angle after the update, and the
// sticky impact flag, which is raised when x*x + y*y + z*z is strictly above
// impact_threshold. A clear transaction (command 1) drops the flag, leaves the
// smoothed angle alone and returns tilt 0. A sample passes through the
// single cordic shift-add stage, which does one rotation per cycle, and
// then through two passes of the shared multiplier for smoothing. A clear
// goes straight to the finish state. The input is not ready while a sample
// is in work. The result sits in an output register, so the next item may
// be accepted while a result still waits to be taken. smoothing_weight
// (byte address 0, saturated at 256) and impact_threshold (byte address 4)
// are written over the apb port; the user must write them only while the
// block is idle, which the block does not enforce; pready is always high.
// ----------------------------------------------------------------------------
module tilt_angle_smoother_with_impact import tas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    tas_in_if.sink            in_ch,
    tas_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // sequencer states
    typedef enum logic [5:0]
    {
        S_IDLE       = 6'b000001,
        S_CORDIC     = 6'b000010,
        S_ANGLE      = 6'b000100,
        S_SMOOTH_NEW = 6'b001000,
        S_SMOOTH_OLD = 6'b010000,
        S_FINISH     = 6'b100000
    } state_t;

    // rounding offset so the arithmetic shift truncates toward zero
    localparam logic signed [ACC_W-1:0] RND = ACC_W'((1 << SMOOTH_SH) - 1);

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    cfg_t         cfg;
    cordic_ctrl_t cordic_ctrl;
    mac_ctrl_t    mac_ctrl;

    logic accept;

    // captured sample
    logic               cmd_reg;
    logic signed [15:0] x_reg, y_reg, zc_reg;

    // angle results of the current sample
    logic signed [A_W-1:0] angle_reg;
    logic signed [7:0]     tilt_reg;
    logic signed [7:0]     old_reg;
    logic                  hit_reg;

    // architectural state
    logic signed [7:0] store_reg;
    logic              flag_reg;

    // output register
    logic              out_valid_reg;
    logic signed [7:0] out_smooth_reg, out_tilt_reg;
    logic              out_impact_reg;
    logic              out_load;

    // shared unit signals
    logic signed [Z_W-1:0]   cordic_z;
    logic signed [MA_W-1:0]  mac_a;
    logic signed [MB_W-1:0]  mac_b;
    logic signed [ACC_W-1:0] mac_acc;

    // angle post-processing
    logic                   z_neg;
    logic [Z_W-1:0]         z_abs, z_shr;
    logic [AMAG_W-1:0]      a_mag;
    logic                   a_neg;
    logic signed [A_W-1:0]  angle_val;
    logic [6:0]             whole_mag;
    logic signed [7:0]      tilt_val, old_val;
    logic signed [A_W-1:0]  old_scaled;

    // smoothing
    logic [W_W-1:0]          w_sat, w_rest;
    logic signed [ACC_W-1:0] num_adj;
    logic signed [7:0]       store_new;
    logic                    last_step;

    tas_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign last_step   = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    // cordic starts straight from the channel on acceptance
    assign cordic_ctrl.load    = accept;
    assign cordic_ctrl.iterate = (state_reg == S_CORDIC);

    tas_cordic u_cordic
    (
        .clk  (clk),
        .ctrl (cordic_ctrl),
        .x    (in_ch.accel_x),
        .y    (in_ch.accel_y),
        .step (step_reg),
        .z    (cordic_z)
    );

    // weight saturates at 1.0
    assign w_sat  = (cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.weight;
    assign w_rest = WEIGHT_ONE - w_sat;

    assign old_scaled = {old_reg, {ANGLE_FRAC_BITS{1'b0}}};

    // multiplier schedule: squares during the first cordic cycles,
    // then new and old angle terms of the smoothing sum
    always_comb
    begin
        mac_ctrl = '0;
        mac_a    = '0;
        mac_b    = '0;
        unique case (state_reg)
            S_CORDIC:
            begin
                if (step_reg == STEP_W'(0))
                begin
                    mac_ctrl = '{en: 1'b1, clr: 1'b1};
                    mac_a    = MA_W'(x_reg);
                    mac_b    = MB_W'(x_reg);
                end
                else if (step_reg == STEP_W'(1))
                begin
                    mac_ctrl = '{en: 1'b1, clr: 1'b0};
                    mac_a    = MA_W'(y_reg);
                    mac_b    = MB_W'(y_reg);
                end
                else if (step_reg == STEP_W'(2))
                begin
                    mac_ctrl = '{en: 1'b1, clr: 1'b0};
                    mac_a    = MA_W'(zc_reg);
                    mac_b    = MB_W'(zc_reg);
                end
            end
            S_SMOOTH_NEW:
            begin
                mac_ctrl = '{en: 1'b1, clr: 1'b1};
                mac_a    = MA_W'(angle_reg);
                mac_b    = $signed(MB_W'(w_sat));
            end
            S_SMOOTH_OLD:
            begin
                mac_ctrl = '{en: 1'b1, clr: 1'b0};
                mac_a    = MA_W'(old_scaled);
                mac_b    = $signed(MB_W'(w_rest));
            end
            S_IDLE, S_ANGLE, S_FINISH:
            begin
                mac_ctrl = '0;
            end
            default:
            begin
                mac_ctrl = '0;
            end
        endcase
    end

    tas_mac u_mac
    (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (mac_acc)
    );

    // cordic angle to fixed point: cut table fraction to ANGLE_FRAC_BITS, clamp to +-90,
    // and the vertical cases when x is zero
    always_comb
    begin
        z_neg = cordic_z[Z_W-1];
        z_abs = z_neg ? -cordic_z : cordic_z;
        z_shr = z_abs >> (TAB_FRAC - ANGLE_FRAC_BITS);
        if (x_reg == 16'sd0)
        begin
            a_mag = (y_reg != 16'sd0) ? ANGLE_LIM : '0;
            a_neg = (y_reg < 16'sd0);
        end
        else
        begin
            a_mag = (z_shr > Z_W'(ANGLE_LIM)) ? ANGLE_LIM : AMAG_W'(z_shr);
            a_neg = z_neg;
        end
        angle_val = a_neg ? -$signed({1'b0, a_mag}) : $signed({1'b0, a_mag});
        whole_mag = 7'(a_mag >> ANGLE_FRAC_BITS);
        tilt_val  = a_neg ? -$signed({1'b0, whole_mag}) : $signed({1'b0, whole_mag});
        // an empty store is seeded with this sample
        old_val   = (store_reg == 8'sd0) ? tilt_val : store_reg;
    end

    // divide by 2^SMOOTH_SH, truncating toward zero
    assign num_adj   = mac_acc + (mac_acc[ACC_W-1] ? RND : '0);
    assign store_new = 8'(num_adj >>> SMOOTH_SH);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    step_next  = '0;
                    state_next = in_ch.command ? S_FINISH : S_CORDIC;
                end
            end
            S_CORDIC:
            begin
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE:
            begin
                state_next = S_SMOOTH_NEW;
            end
            S_SMOOTH_NEW:
            begin
                state_next = S_SMOOTH_OLD;
            end
            S_SMOOTH_OLD:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            store_reg     <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (cmd_reg)
                begin
                    flag_reg <= 1'b0;
                end
                else
                begin
                    store_reg <= store_new;
                    flag_reg  <= flag_reg | hit_reg;
                end
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= in_ch.command;
            x_reg   <= in_ch.accel_x;
            y_reg   <= in_ch.accel_y;
            zc_reg  <= in_ch.accel_z;
        end
        // squares are complete once the third product is accumulated
        if (state_reg == S_CORDIC && step_reg == STEP_W'(3))
        begin
            hit_reg <= (mac_acc > $signed(ACC_W'(cfg.threshold)));
        end
        if (state_reg == S_ANGLE)
        begin
            angle_reg <= angle_val;
            tilt_reg  <= tilt_val;
            old_reg   <= old_val;
        end
        if (out_load)
        begin
            if (cmd_reg)
            begin
                out_smooth_reg <= store_reg;
                out_tilt_reg   <= 8'sd0;
                out_impact_reg <= 1'b0;
            end
            else
            begin
                out_smooth_reg <= store_new;
                out_tilt_reg   <= tilt_reg;
                out_impact_reg <= flag_reg | hit_reg;
            end
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.smoothed_angle = out_smooth_reg;
    assign out_ch.tilt_angle     = out_tilt_reg;
    assign out_ch.impact         = out_impact_reg;

endmodule

### rtl/tas_checker.sv
// ----------------------------------------------------------------------------
// tas_checker
// port-level checks of the tilt smoother, bound to the top level
// ----------------------------------------------------------------------------
module tas_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [7:0] smoothed_angle,
    input logic signed [7:0] tilt_angle,
    input logic              impact
);

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(smoothed_angle)
            && $stable(tilt_angle) && $stable(impact))
        else $error("stalled result changed");

    // the block is busy right after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a transaction");

    // angles stay within a quarter turn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> smoothed_angle <= 8'sd90 && smoothed_angle >= -8'sd90
            && tilt_angle <= 8'sd90 && tilt_angle >= -8'sd90)
        else $error("angle out of range");

    // a fresh result only comes from a busy sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");

endmodule

bind tilt_angle_smoother_with_impact tas_checker u_tas_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .smoothed_angle (out_ch.smoothed_angle),
    .tilt_angle     (out_ch.tilt_angle),
    .impact         (out_ch.impact)
);
